// ===== rtl/v2ns_pkg.sv =====
// v2ns_pkg: shared types and constants for the vector normalize-and-scale block
// no dependencies
`timescale 1ns / 1ps
package v2ns_pkg;

	localparam int SqrtSteps = 16;
	localparam int DivSteps  = 32;

	typedef enum logic [0:0] {
		REG_ZERO_LENGTH = 1'b0,
		REG_UNIT_LENGTH = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic signed [15:0] scale_factor;
		logic signed [31:0] tag_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [31:0] out_z;
	} out_beat_t;

	// item carried through the square root cells
	typedef struct packed {
		logic               vld;
		in_beat_t           beat;
		logic [31:0]        rem;
		logic [31:0]        root;
	} sq_item_t;

	// item carried through the divide cells
	typedef struct packed {
		logic               vld;
		logic               skip;
		logic               neg_x;
		logic               neg_y;
		logic signed [15:0] scale_factor;
		logic signed [31:0] tag_z;
		logic [16:0]        den;
		logic [31:0]        num_x;
		logic [31:0]        num_y;
		logic [32:0]        rem_x;
		logic [32:0]        rem_y;
	} dv_item_t;

	function automatic logic signed [15:0] sat_scale(input logic signed [31:0] c,
		input logic signed [15:0] s);
		logic signed [47:0] p;
		logic signed [39:0] q;
		p = c * s;
		q = p[47:8];
		if (q > 40'sd32767) return 16'sh7fff;
		else if (q < -40'sd32768) return 16'sh8000;
		return q[15:0];
	endfunction

endpackage

// ===== rtl/v2ns_sqrt_cell.sv =====
// v2ns_sqrt_cell: one digit step of a restoring integer square root
// depends on v2ns_pkg
`timescale 1ns / 1ps
module v2ns_sqrt_cell
	import v2ns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] step,
	input  sq_item_t   d,
	output sq_item_t   q
);
	logic [31:0] trial;
	logic [31:0] bitv;
	sq_item_t    nx;

	// step k handles bit weight 4^(15-k)
	always_comb begin
		nx = d;
		bitv = 32'd1 << (5'd30 - {step, 1'b0});
		trial = d.root + bitv;
		if (d.rem >= trial) begin
			nx.rem  = d.rem - trial;
			nx.root = (d.root >> 1) + bitv;
		end else begin
			nx.root = d.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q <= '0;
		else q <= nx;
	end
endmodule

// ===== rtl/v2ns_div_cell.sv =====
// v2ns_div_cell: one quotient bit of two parallel restoring divisions
// depends on v2ns_pkg
`timescale 1ns / 1ps
module v2ns_div_cell
	import v2ns_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dv_item_t d,
	output dv_item_t q
);
	dv_item_t    nx;
	logic [32:0] px;
	logic [32:0] py;

	// quotient bits shift into the low end of num as numerator bits leave the top
	always_comb begin
		nx = d;
		px = {d.rem_x[31:0], d.num_x[31]};
		py = {d.rem_y[31:0], d.num_y[31]};
		nx.num_x = {d.num_x[30:0], 1'b0};
		nx.num_y = {d.num_y[30:0], 1'b0};
		if (px >= {16'd0, d.den}) begin
			nx.rem_x = px - {16'd0, d.den};
			nx.num_x[0] = 1'b1;
		end else begin
			nx.rem_x = px;
		end
		if (py >= {16'd0, d.den}) begin
			nx.rem_y = py - {16'd0, d.den};
			nx.num_y[0] = 1'b1;
		end else begin
			nx.rem_y = py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q <= '0;
		else q <= nx;
	end
endmodule

// ===== rtl/vector2_normalize_scale.sv =====
// vector2_normalize_scale: top level, sqrt chain, divide chain and scale stage
// depends on v2ns_pkg, v2ns_sqrt_cell, v2ns_div_cell
`timescale 1ns / 1ps
// pipeline from start to result strobe: 1 square stage, 16 sqrt cells,
// 1 setup stage, 32 divide cells, 1 multiply stage, 1 output stage
// throughput: one vector per cycle, busy is always low
// reset: asynchronous active low, clears valid bits, zero_length=0, unit_length=256
// the receiver cannot stall, each result is shown for exactly one cycle
module vector2_normalize_scale
	import v2ns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_beat_t    in_beat,
	output logic        done,
	output out_beat_t   out_beat,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] zero_length_q;
	logic [14:0] unit_length_q;

	// config writes, index 1 bit covers both registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_length_q <= '0;
			unit_length_q <= 15'd256;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ZERO_LENGTH: zero_length_q <= cfg_data;
				REG_UNIT_LENGTH: unit_length_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: sum of squares
	sq_item_t sq_chain [0:SqrtSteps];
	sq_item_t sq_s1;
	logic signed [31:0] sxx;
	logic signed [31:0] syy;
	always_comb begin
		sxx = in_beat.vec_x * in_beat.vec_x;
		syy = in_beat.vec_y * in_beat.vec_y;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_s1 <= '0;
		else begin
			sq_s1.vld  <= start;
			sq_s1.beat <= in_beat;
			sq_s1.rem  <= 32'(sxx) + 32'(syy);
			sq_s1.root <= '0;
		end
	end
	assign sq_chain[0] = sq_s1;

	// sqrt cells, one per result bit
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sq
		v2ns_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step(4'(k)),
			.d(sq_chain[k]), .q(sq_chain[k+1])
		);
	end

	// setup stage: decide skip, take magnitudes times unit
	sq_item_t    sq_o;
	dv_item_t    dv_chain [0:DivSteps];
	dv_item_t    dv_s18;
	logic [15:0] len;
	logic [15:0] mag_x;
	logic [15:0] mag_y;
	logic        skip;
	assign sq_o = sq_chain[SqrtSteps];
	always_comb begin
		len   = sq_o.root[15:0];
		mag_x = sq_o.beat.vec_x[15] ? 16'(-sq_o.beat.vec_x) : sq_o.beat.vec_x;
		mag_y = sq_o.beat.vec_y[15] ? 16'(-sq_o.beat.vec_y) : sq_o.beat.vec_y;
		skip  = (len == zero_length_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s18 <= '0;
		else begin
			dv_s18.vld          <= sq_o.vld;
			dv_s18.skip         <= skip;
			dv_s18.neg_x        <= sq_o.beat.vec_x[15];
			dv_s18.neg_y        <= sq_o.beat.vec_y[15];
			dv_s18.scale_factor <= sq_o.beat.scale_factor;
			dv_s18.tag_z        <= sq_o.beat.tag_z;
			dv_s18.den          <= {1'b0, len};
			// on skip, numerator is loaded with the raw signed component instead of the scaled magnitude
			dv_s18.num_x <= skip ? 32'(sq_o.beat.vec_x) : 32'(mag_x) * 32'(unit_length_q);
			dv_s18.num_y <= skip ? 32'(sq_o.beat.vec_y) : 32'(mag_y) * 32'(unit_length_q);
			dv_s18.rem_x <= '0;
			dv_s18.rem_y <= '0;
		end
	end
	assign dv_chain[0] = dv_s18;

	// divide cells; a skipped item's quotient is ignored at the end of the chain
	for (genvar k = 0; k < DivSteps; k++) begin : g_dv
		v2ns_div_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.d(dv_chain[k]), .q(dv_chain[k+1])
		);
	end

	// after 32 cells the raw numerator is gone, so carry skip values beside the chain
	logic signed [15:0] raw_x_s [0:DivSteps];
	logic signed [15:0] raw_y_s [0:DivSteps];
	always_ff @(posedge clk) begin
		raw_x_s[0] <= sq_o.beat.vec_x;
		raw_y_s[0] <= sq_o.beat.vec_y;
		for (int i = 0; i < DivSteps; i++) begin
			raw_x_s[i+1] <= raw_x_s[i];
			raw_y_s[i+1] <= raw_y_s[i];
		end
	end

	// select component, sign restore, multiply
	dv_item_t           dv_o;
	logic signed [31:0] cx;
	logic signed [31:0] cy;
	assign dv_o = dv_chain[DivSteps];
	always_comb begin
		if (dv_o.skip) begin
			cx = 32'(raw_x_s[DivSteps]);
			cy = 32'(raw_y_s[DivSteps]);
		end else if (dv_o.den == '0) begin
			cx = '0;
			cy = '0;
		end else begin
			cx = dv_o.neg_x ? -$signed(dv_o.num_x) : $signed(dv_o.num_x);
			cy = dv_o.neg_y ? -$signed(dv_o.num_y) : $signed(dv_o.num_y);
		end
	end

	logic signed [47:0] px_s1;
	logic signed [47:0] py_s1;
	logic signed [31:0] z_s1;
	logic               vld_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= dv_o.vld;
	end
	always_ff @(posedge clk) begin
		px_s1 <= cx * dv_o.scale_factor;
		py_s1 <= cy * dv_o.scale_factor;
		z_s1  <= dv_o.tag_z;
	end

	// shift by 8 (floor) and saturate
	function automatic logic signed [15:0] sat16(input logic signed [47:0] p);
		logic signed [39:0] q;
		q = p[47:8];
		if (q > 40'sd32767) return 16'sh7fff;
		else if (q < -40'sd32768) return 16'sh8000;
		return q[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s1;
	end
	always_ff @(posedge clk) begin
		out_beat.out_x <= sat16(px_s1);
		out_beat.out_y <= sat16(py_s1);
		out_beat.out_z <= z_s1;
	end

	// start reaches the chain entry, valid reaches done, busy stays low, zero length gives zero products
	a_chain_in: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> sq_chain[0].vld) else $error("start lost at chain entry");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done) else $error("result strobe missing");
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_o.vld && !dv_o.skip && dv_o.den == '0) |=> (px_s1 == '0 && py_s1 == '0))
		else $error("zero length not cleared");
endmodule
